>>> rtl/pbc_pkg.sv
package pbc_pkg;

  // Default coordinate width and fraction bits of the clip parameter t.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_FRAC = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WEST  = 2'd0;
  localparam logic [1:0] REG_EAST  = 2'd1;
  localparam logic [1:0] REG_SOUTH = 2'd2;
  localparam logic [1:0] REG_NORTH = 2'd3;

  // Reset values of the box, cut to the configured width where used.
  localparam logic signed [63:0] WEST_RST  = -64'sd1800000000;
  localparam logic signed [63:0] EAST_RST  = 64'sd1800000000;
  localparam logic signed [63:0] SOUTH_RST = -64'sd900000000;
  localparam logic signed [63:0] NORTH_RST = 64'sd900000000;

endpackage

>>> rtl/pbc_if.sv
interface pbc_vertex_if #(parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-2:0] vertex_y;
  logic                          first_vertex;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, first_vertex, last_vertex,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, first_vertex, last_vertex,
                output ready);
endinterface

interface pbc_result_if #(parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-2:0] out_y;
  logic                          starts_run;
  logic                          last_result;

  modport source (output valid, out_x, out_y, starts_run, last_result, input ready);
  modport sink (input valid, out_x, out_y, starts_run, last_result, output ready);
endinterface

>>> rtl/pbc_div.sv
module pbc_div #(
  parameter int NW = pbc_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NW-1:0]     num,
  input  logic [NW-1:0]     den,
  output logic              done,
  output logic [pbc_pkg::T_FRAC:0] quot
);

  localparam int TF    = pbc_pkg::T_FRAC;
  localparam int CNT_W = $clog2(TF);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NW:0]      rem;
  logic [NW-1:0]    dn;
  logic [NW:0]      rem2;
  logic             fits;

  always_comb begin
    rem2 = {rem[NW-1:0], 1'b0};
    fits = rem2 >= {1'b0, dn};
  end

  // Restoring division, one quotient bit per cycle; num >= den gives one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= den) begin
          quot <= {1'b1, {TF{1'b0}}};
          done <= 1'b1;
        end else begin
          rem  <= {1'b0, num};
          dn   <= den;
          quot <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (fits) begin
          rem  <= rem2 - {1'b0, dn};
          quot <= {quot[TF-1:0], 1'b1};
        end else begin
          rem  <= rem2;
          quot <= {quot[TF-1:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TF - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/polyline_box_clipper.sv
// Channel  Direction  Content
// vin      in         vertex_x, vertex_y, first_vertex, last_vertex
// rout     out        out_x, out_y, starts_run, last_result
// apb      in         box_west, box_east, box_south, box_north
//
// A vertex with the first mark only starts a run; it gives a result only when it
// is also marked last and lies in the box. Any other vertex runs up to four clip
// edges, each with or without a pass through the serial divider at one quotient
// bit a cycle, then four interpolations through a shift-add multiplier at one
// bit of t a cycle, and a decide step. Results wait for ready. The block takes
// no item until its last result is taken. Reset is synchronous and loads the
// default box at once.
module polyline_box_clipper #(
  parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF,
  localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = (COORD_WIDTH > 32) ? 5 : 4
) (
  input  logic              clk,
  input  logic              rst,
  pbc_vertex_if.sink        vin,
  pbc_result_if.source      rout,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW = COORD_WIDTH;
  localparam int YW = COORD_WIDTH - 1;
  localparam int W  = COORD_WIDTH + 2;
  localparam int NW = COORD_WIDTH + 1;
  localparam int TF = pbc_pkg::T_FRAC;
  localparam int TW = TF + 1;
  localparam int PW = NW + TW;
  localparam int CNT_W = $clog2(TW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_EDGE   = 4'd2;
  localparam logic [3:0] S_DEC    = 4'd3;
  localparam logic [3:0] S_DIVW   = 4'd4;
  localparam logic [3:0] S_MSET   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_CLMP   = 4'd8;
  localparam logic [3:0] S_DECIDE = 4'd9;
  localparam logic [3:0] S_OUTA   = 4'd10;
  localparam logic [3:0] S_OUTB   = 4'd11;

  logic [3:0] state;

  logic signed [CW-1:0] box_west, box_east;
  logic signed [YW-1:0] box_south, box_north;
  logic signed [CW-1:0] prev_x, run_end_x, cx0, cx1;
  logic signed [YW-1:0] prev_y, run_end_y, cy0, cy1;
  logic                 run_open;

  logic signed [W-1:0]  ax, ay, bx, by, dx, dy, p, q, sumv;
  logic [TW-1:0]        t0, t1, tt;
  logic [1:0]           edge_idx, k;
  logic                 last_in, emit_start, low_side, mneg;
  logic [PW-1:0]        acc, mcand;
  logic [CNT_W-1:0]     cnt;

  logic                 div_start, div_done;
  logic [TW-1:0]        div_q;
  logic [NW-1:0]        np, nq;
  logic signed [W-1:0]  ap, aq, lo, hi, v1, v2, aval, dsel;
  logic                 in_box, wr_en, need_start;
  logic [1:0]           reg_idx;

  pbc_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nq),
    .den   (np),
    .done  (div_done),
    .quot  (div_q)
  );

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      pbc_pkg::REG_WEST:  prdata = DATA_W'(box_west);
      pbc_pkg::REG_EAST:  prdata = DATA_W'(box_east);
      pbc_pkg::REG_SOUTH: prdata = DATA_W'(box_south);
      default:            prdata = DATA_W'(box_north);
    endcase
  end

  always_comb begin
    ap = p[W-1] ? -p : p;
    aq = q[W-1] ? -q : q;
    np = ap[NW-1:0];
    nq = aq[NW-1:0];
    div_start = 1'b0;
    if (state == S_DEC && p != '0) begin
      if (p[W-1]) div_start = !(q[W-1] == 1'b0 && q != '0) && !(nq > np);
      else        div_start = !q[W-1] && (nq < np);
    end
  end

  always_comb begin
    in_box = vin.vertex_x >= box_west && vin.vertex_x <= box_east &&
             vin.vertex_y >= box_south && vin.vertex_y <= box_north;
    aval = k[0] ? ay : ax;
    dsel = k[0] ? dy : dx;
    if (k[0]) begin
      lo = {{3{box_south[YW-1]}}, box_south};
      hi = {{3{box_north[YW-1]}}, box_north};
    end else begin
      lo = {{2{box_west[CW-1]}}, box_west};
      hi = {{2{box_east[CW-1]}}, box_east};
    end
    v1 = (sumv < lo) ? lo : sumv;
    v2 = (v1 > hi) ? hi : v1;
    need_start = !run_open || run_end_x != cx0 || run_end_y != cy0;
  end

  assign vin.ready        = state == S_IDLE;
  assign rout.valid       = state == S_OUTA || state == S_OUTB;
  assign rout.out_x       = (state == S_OUTA) ? cx0 : cx1;
  assign rout.out_y       = (state == S_OUTA) ? cy0 : cy1;
  assign rout.starts_run  = (state == S_OUTA) ? 1'b1 : emit_start;
  assign rout.last_result = state == S_OUTB;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      box_west  <= pbc_pkg::WEST_RST[CW-1:0];
      box_east  <= pbc_pkg::EAST_RST[CW-1:0];
      box_south <= pbc_pkg::SOUTH_RST[YW-1:0];
      box_north <= pbc_pkg::NORTH_RST[YW-1:0];
      prev_x    <= '0;
      prev_y    <= '0;
      run_end_x <= '0;
      run_end_y <= '0;
      run_open  <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_idx)
          pbc_pkg::REG_WEST:  box_west  <= pwdata[CW-1:0];
          pbc_pkg::REG_EAST:  box_east  <= pwdata[CW-1:0];
          pbc_pkg::REG_SOUTH: box_south <= pwdata[YW-1:0];
          default:            box_north <= pwdata[YW-1:0];
        endcase
      end
      case (state)
        S_IDLE: begin
          if (vin.valid) begin
            prev_x <= vin.vertex_x;
            prev_y <= vin.vertex_y;
            if (vin.first_vertex) begin
              run_open <= 1'b0;
              cx1 <= vin.vertex_x;
              cy1 <= vin.vertex_y;
              emit_start <= 1'b1;
              if (vin.last_vertex && in_box) state <= S_OUTB;
            end else begin
              ax <= {{2{prev_x[CW-1]}}, prev_x};
              ay <= {{3{prev_y[YW-1]}}, prev_y};
              bx <= {{2{vin.vertex_x[CW-1]}}, vin.vertex_x};
              by <= {{3{vin.vertex_y[YW-1]}}, vin.vertex_y};
              last_in <= vin.last_vertex;
              emit_start <= 1'b0;
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          dx <= bx - ax;
          dy <= by - ay;
          t0 <= '0;
          t1 <= {1'b1, {TF{1'b0}}};
          edge_idx <= '0;
          state <= S_EDGE;
        end
        S_EDGE: begin
          case (edge_idx)
            2'd0: begin
              p <= -dx;
              q <= ax - {{2{box_west[CW-1]}}, box_west};
            end
            2'd1: begin
              p <= dx;
              q <= {{2{box_east[CW-1]}}, box_east} - ax;
            end
            2'd2: begin
              p <= -dy;
              q <= ay - {{3{box_south[YW-1]}}, box_south};
            end
            default: begin
              p <= dy;
              q <= {{3{box_north[YW-1]}}, box_north} - ay;
            end
          endcase
          state <= S_DEC;
        end
        S_DEC: begin
          low_side <= p[W-1];
          if (div_start) begin
            state <= S_DIVW;
          end else if ((p == '0 && q[W-1]) ||
                       (p[W-1] && !(q[W-1] == 1'b0 && q != '0) && nq > np) ||
                       (!p[W-1] && p != '0 && q[W-1])) begin
            run_open <= 1'b0;
            state <= S_IDLE;
          end else if (edge_idx == 2'd3) begin
            k <= '0;
            state <= S_MSET;
          end else begin
            edge_idx <= edge_idx + 1'b1;
            state <= S_EDGE;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if ((low_side && div_q > t1) || (!low_side && div_q < t0)) begin
              run_open <= 1'b0;
              state <= S_IDLE;
            end else begin
              if (low_side && div_q > t0) t0 <= div_q;
              if (!low_side && div_q < t1) t1 <= div_q;
              if (edge_idx == 2'd3) begin
                k <= '0;
                state <= S_MSET;
              end else begin
                edge_idx <= edge_idx + 1'b1;
                state <= S_EDGE;
              end
            end
          end
        end
        S_MSET: begin
          // Rounding half is preloaded so the product lands already rounded.
          mneg  <= dsel[W-1];
          mcand <= {{(PW-W){1'b0}}, (dsel[W-1] ? -dsel : dsel)};
          tt    <= k[1] ? t1 : t0;
          acc   <= {{(PW-TF){1'b0}}, 1'b1, {(TF-1){1'b0}}};
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (tt[0]) acc <= acc + mcand;
          mcand <= {mcand[PW-2:0], 1'b0};
          tt    <= {1'b0, tt[TW-1:1]};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(TF)) state <= S_FIN;
        end
        S_FIN: begin
          sumv  <= mneg ? aval - $signed(acc[PW-1:TF]) : aval + $signed(acc[PW-1:TF]);
          state <= S_CLMP;
        end
        S_CLMP: begin
          case (k)
            2'd0:    cx0 <= v2[CW-1:0];
            2'd1:    cy0 <= v2[YW-1:0];
            2'd2:    cx1 <= v2[CW-1:0];
            default: cy1 <= v2[YW-1:0];
          endcase
          if (k == 2'd3) begin
            state <= S_DECIDE;
          end else begin
            k <= k + 1'b1;
            state <= S_MSET;
          end
        end
        S_DECIDE: begin
          run_end_x <= cx1;
          run_end_y <= cy1;
          run_open  <= !last_in;
          state <= need_start ? S_OUTA : S_OUTB;
        end
        S_OUTA: begin
          if (rout.ready) state <= S_OUTB;
        end
        S_OUTB: begin
          if (rout.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rout.valid |-> !vin.ready)
    else $error("input taken while a result is pending");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider finished outside its wait state");

  a_t_order: assert property (@(posedge clk) disable iff (rst)
    state == S_MSET |-> t0 <= t1)
    else $error("clip interval inverted");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (rout.valid && rout.ready && rout.last_result) |=> vin.ready)
    else $error("not idle after the final result");

endmodule
